@@ src/pip_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int FIELD_W = 32;
  localparam int IDX_W   = 5;
  localparam int CNT_W   = 6;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CNT_W-1:0] EDGE_COUNT_RESET = 6'd32;

  typedef struct packed {
    logic                      opcode;
    logic [IDX_W-1:0]          edge_index;
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] point_x;
    logic signed [FIELD_W-1:0] point_y;
    logic                      last_point;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] crossings;
    logic             batch_end;
  } out_item_t;

  // classified request between front and back
  typedef struct packed {
    logic               query;
    logic [IDX_W-1:0]   edge_index;
    logic [FIELD_W-1:0] ax;
    logic [FIELD_W-1:0] ay;
    logic [FIELD_W-1:0] bx;
    logic [FIELD_W-1:0] by;
    logic               last_point;
  } req_t;

endpackage

`default_nettype wire

@@ src/pip_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output      logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ src/pip_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_front #(
  parameter int MAX_EDGES = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire pip_pkg::in_item_t in_i,
  input  wire logic              in_valid_i,
  output      logic              in_stall_o,
  output      pip_pkg::req_t     req_o,
  output      logic              req_valid_o,
  input  wire logic              req_pop_i
);

  import pip_pkg::*;

  localparam logic [1:0] FULL = 2'd2;

  req_t       slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] fill_q;
  logic       keep;
  logic       push;
  logic       pop;
  req_t       req_new;

  // loads beyond the table are dropped here
  always_comb begin
    keep = (in_i.opcode == OP_QUERY) || (int'(in_i.edge_index) < MAX_EDGES);
    req_new.query      = (in_i.opcode == OP_QUERY);
    req_new.edge_index = in_i.edge_index;
    req_new.ax         = req_new.query ? in_i.point_x : in_i.first_x;
    req_new.ay         = req_new.query ? in_i.point_y : in_i.first_y;
    req_new.bx         = in_i.second_x;
    req_new.by         = in_i.second_y;
    req_new.last_point = in_i.last_point;
  end

  assign in_stall_o  = (fill_q == FULL);
  assign req_valid_o = (fill_q != 2'd0);
  assign req_o       = slot_q[rd_ptr_q];
  assign push        = in_valid_i && !in_stall_o && keep;
  assign pop         = req_pop_i && req_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= req_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push, pop})
        2'b10:   fill_q <= fill_q + 2'd1;
        2'b01:   fill_q <= fill_q - 2'd1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/pip_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_back #(
  parameter int MAX_EDGES  = 32,
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [pip_pkg::CNT_W-1:0]    cfg_data_i,
  input  wire pip_pkg::req_t                req_i,
  input  wire logic                         req_valid_i,
  output      logic                         req_pop_o,
  output      logic                         ram_wr_en_o,
  output      logic [$clog2(MAX_EDGES)-1:0] ram_wr_addr_o,
  output      logic [4*COORD_BITS-1:0]      ram_wr_data_o,
  output      logic                         ram_rd_en_o,
  output      logic [$clog2(MAX_EDGES)-1:0] ram_rd_addr_o,
  input  wire logic [4*COORD_BITS-1:0]      ram_rd_data_i,
  output      pip_pkg::out_item_t           out_o,
  output      logic                         out_valid_o,
  input  wire logic                         out_stall_i
);

  import pip_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int AW = $clog2(MAX_EDGES);
  localparam int NW = ($clog2(MAX_EDGES + 1) > CNT_W) ? $clog2(MAX_EDGES + 1) : CNT_W;
  localparam logic [NW-1:0] MAX_N = NW'(MAX_EDGES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  function automatic logic [CW-1:0] mag_of(input logic [CW:0] v);
    logic [CW:0] n;
    n = v[CW] ? (~v + 1'b1) : v;
    return n[CW-1:0];
  endfunction

  logic [1:0]           state_q, state_d;
  logic [CNT_W-1:0]     edge_count_q;
  logic [NW-1:0]        j_q, j_d;
  logic [NW-1:0]        n_sat;
  logic signed [CW-1:0] px_q, py_q;
  logic                 last_q;
  logic [CNT_W-1:0]     acc_q;
  logic                 start;
  logic                 finish;
  out_item_t            out_q;
  logic                 out_valid_q;

  // pipeline valids: ram data, differences, products
  logic                 rd_v_q, a_v_q, b_v_q;

  logic signed [CW-1:0] x1, y1, x2, y2;
  logic                 straddle;
  logic [CW:0]          dy_w, dx_w, rx_w, ry_w;
  logic [CW-1:0]        mag_rx_q, mag_dy_q, mag_ry_q, mag_dx_q;
  logic                 neg_rx_q, neg_dx_q;
  logic [2*CW-1:0]      prod_l, prod_r;
  logic [2*CW-1:0]      prod_l_q, prod_r_q;
  logic                 neg_l_q, neg_r_q;
  logic                 an, bn, hit;

  assign n_sat = (NW'(edge_count_q) > MAX_N) ? MAX_N : NW'(edge_count_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    req_pop_o   = 1'b0;
    ram_rd_en_o = 1'b0;
    start       = 1'b0;
    finish      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          req_pop_o = 1'b1;
          if (req_i.query) begin
            start   = 1'b1;
            j_d     = '0;
            state_d = (n_sat == '0) ? ST_DRAIN : ST_RUN;
          end
        end
      end
      ST_RUN: begin
        ram_rd_en_o = 1'b1;
        j_d         = j_q + 1'b1;
        if (j_q == n_sat - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !a_v_q && !b_v_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  assign ram_wr_en_o   = (state_q == ST_IDLE) && req_valid_i && !req_i.query;
  assign ram_wr_addr_o = AW'(req_i.edge_index);
  assign ram_wr_data_o = {req_i.ax[CW-1:0], req_i.ay[CW-1:0],
                          req_i.bx[CW-1:0], req_i.by[CW-1:0]};
  assign ram_rd_addr_o = j_q[AW-1:0];

  // edge classification and differences
  always_comb begin
    x1 = ram_rd_data_i[4*CW-1:3*CW];
    y1 = ram_rd_data_i[3*CW-1:2*CW];
    x2 = ram_rd_data_i[2*CW-1:CW];
    y2 = ram_rd_data_i[CW-1:0];
    straddle = ((y1 <= py_q) && (y2 > py_q)) || ((y1 > py_q) && (y2 <= py_q));
    dy_w = {y2[CW-1], y2} - {y1[CW-1], y1};
    dx_w = {x2[CW-1], x2} - {x1[CW-1], x1};
    rx_w = {px_q[CW-1], px_q} - {x1[CW-1], x1};
    ry_w = {py_q[CW-1], py_q} - {y1[CW-1], y1};
  end

  assign prod_l = mag_rx_q * mag_dy_q;
  assign prod_r = mag_ry_q * mag_dx_q;

  // rx*|dy| < |ry|*dx in sign and magnitude
  always_comb begin
    an  = neg_l_q && (prod_l_q != '0);
    bn  = neg_r_q && (prod_r_q != '0);
    hit = (an != bn) ? an : (an ? (prod_l_q > prod_r_q) : (prod_l_q < prod_r_q));
  end

  always_ff @(posedge clk_i) begin
    if (start) begin
      px_q   <= req_i.ax[CW-1:0];
      py_q   <= req_i.ay[CW-1:0];
      last_q <= req_i.last_point;
    end
    mag_rx_q <= mag_of(rx_w);
    mag_dy_q <= mag_of(dy_w);
    mag_ry_q <= mag_of(ry_w);
    mag_dx_q <= mag_of(dx_w);
    neg_rx_q <= rx_w[CW];
    neg_dx_q <= dx_w[CW];
    prod_l_q <= prod_l;
    prod_r_q <= prod_r;
    neg_l_q  <= neg_rx_q;
    neg_r_q  <= neg_dx_q;
    if (finish) begin
      out_q.crossings <= acc_q;
      out_q.batch_end <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      edge_count_q <= EDGE_COUNT_RESET;
      j_q          <= '0;
      acc_q        <= '0;
      rd_v_q       <= 1'b0;
      a_v_q        <= 1'b0;
      b_v_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      if (cfg_valid_i) begin
        edge_count_q <= cfg_data_i;
      end
      rd_v_q <= ram_rd_en_o;
      a_v_q  <= rd_v_q && straddle;
      b_v_q  <= a_v_q;
      if (start) begin
        acc_q <= '0;
      end else if (b_v_q && hit) begin
        acc_q <= acc_q + 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ src/point_in_polygon_crossing_count_top.sv @@
// point-in-polygon crossing counter
// input channel (in_i, in_valid_i, in_stall_o): a request with opcode load
//   writes one edge (first and second point) at edge_index; a load whose
//   index is MAX_EDGES or above is dropped. opcode query gives a point.
// output channel (out_o, out_valid_o, out_stall_i): one result per query,
//   the number of edges in use crossed by the rightward ray from the point,
//   with batch_end copied from last_point. loads give no result.
// config channel (cfg_data_i, cfg_valid_i, cfg_ready_o): edge_count, the
//   edges in use counted from entry zero, capped at MAX_EDGES; write it only
//   while idle. ready is always high.
// a query reads its n entries one after another, n = edge_count capped at
//   MAX_EDGES; each edge passes the ram read, difference and product registers
//   and the count is registered once they have drained. the edge table has one
//   read port and one edge is tested per cycle, so a query starts only once the
//   previous count has been taken into the result register.
// a two-entry request queue sits in front of the edge unit, so requests are
//   taken while a result waits on a stalled output; when the queue is full
//   in_stall_o is high. the result register holds while out_stall_i is high.
// reset clears the queue, the sequencer and the output valid and sets
//   edge_count to 32. edge entries are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_crossing_count_top #(
  parameter int MAX_EDGES  = 32,
  parameter int COORD_BITS = 32
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pip_pkg::in_item_t         in_i,
  input  wire logic                      in_valid_i,
  output      logic                      in_stall_o,
  output      pip_pkg::out_item_t        out_o,
  output      logic                      out_valid_o,
  input  wire logic                      out_stall_i,
  input  wire logic [pip_pkg::CNT_W-1:0] cfg_data_i,
  input  wire logic                      cfg_valid_i,
  output      logic                      cfg_ready_o
);

  import pip_pkg::*;

  localparam int AW = $clog2(MAX_EDGES);
  localparam int EW = 4 * COORD_BITS;

  req_t          req;
  logic          req_valid;
  logic          req_pop;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [EW-1:0] rd_data;

  assign cfg_ready_o = 1'b1;

  pip_front #(
    .MAX_EDGES(MAX_EDGES)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .in_valid_i,
    .in_stall_o,
    .req_o       (req),
    .req_valid_o (req_valid),
    .req_pop_i   (req_pop)
  );

  pip_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_EDGES)
  ) u_edges (
    .clk_i,
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pip_back #(
    .MAX_EDGES (MAX_EDGES),
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i,
    .req_i         (req),
    .req_valid_i   (req_valid),
    .req_pop_o     (req_pop),
    .ram_wr_en_o   (wr_en),
    .ram_wr_addr_o (wr_addr),
    .ram_wr_data_o (wr_data),
    .ram_rd_en_o   (rd_en),
    .ram_rd_addr_o (rd_addr),
    .ram_rd_data_i (rd_data),
    .out_o,
    .out_valid_o,
    .out_stall_i
  );

endmodule

`default_nettype wire

@@ src/pip_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pip_chk (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire pip_pkg::in_item_t         in_i,
  input wire logic                      in_valid_i,
  input wire logic                      in_stall_o,
  input wire pip_pkg::out_item_t        out_o,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic [pip_pkg::CNT_W-1:0] cfg_data_i,
  input wire logic                      cfg_valid_i,
  input wire logic                      cfg_ready_o
);

  import pip_pkg::*;

  logic [2:0] pending_q;
  logic       q_in;
  logic       r_out;
  logic       cfg_take;

  assign q_in     = in_valid_i && !in_stall_o && (in_i.opcode == OP_QUERY);
  assign r_out    = out_valid_o && !out_stall_i;
  assign cfg_take = cfg_valid_i && cfg_ready_o && (cfg_data_i != '0);

  // queries accepted but not yet answered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 3'd0;
    end else begin
      unique case ({q_in, r_out})
        2'b10:   pending_q <= pending_q + 3'd1;
        2'b01:   pending_q <= pending_q - 3'd1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != 3'd0))
    else $error("result without an open query");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q <= 3'd4) || cfg_take)
    else $error("more open queries than the block can hold");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("stalled result dropped or changed");

  a_reset_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind point_in_polygon_crossing_count_top pip_chk u_pip_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_i        (in_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_o       (out_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .cfg_data_i  (cfg_data_i),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pip_pkg::*;

  localparam int TABLE_DEPTH   = 32;
  localparam int ITEM_GOAL     = 1050;
  localparam int CALM_ITEMS    = 150;
  localparam int SETTLE_CYCLES = 50;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef logic signed [127:0] wide_t;

  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_MAX = 32'sh7fff_ffff;

  typedef enum int {SPAN_TINY, SPAN_MID, SPAN_FULL, SPAN_EXTREME} span_e;

  class crossing_scoreboard;
    coord_t ax [TABLE_DEPTH];
    coord_t ay [TABLE_DEPTH];
    coord_t bx [TABLE_DEPTH];
    coord_t by [TABLE_DEPTH];
    logic [CNT_W-1:0] edge_count;
    out_item_t crossings_q[$];
    int unsigned mismatches;

    function new();
      edge_count = EDGE_COUNT_RESET;
      mismatches = 0;
    endfunction

    function void set_edge_count(input logic [CNT_W-1:0] value);
      edge_count = value;
    endfunction

    function int pending();
      return crossings_q.size();
    endfunction

    // exact test: px < x1 + ry*dx/dy, cross-multiplied by |dy|
    function bit ray_crosses(input coord_t px, input coord_t py, input int j);
      wide_t x1, y1, x2, y2, qx, qy, dy, dx, rx, ry;
      x1 = ax[j];
      y1 = ay[j];
      x2 = bx[j];
      y2 = by[j];
      qx = px;
      qy = py;
      if (!((y1 <= qy && y2 > qy) || (y1 > qy && y2 <= qy))) return 1'b0;
      dy = y2 - y1;
      dx = x2 - x1;
      rx = qx - x1;
      ry = qy - y1;
      if (dy < 0) dy = -dy;
      if (ry < 0) ry = -ry;
      return (rx * dy) < (ry * dx);
    endfunction

    function void note_request(input in_item_t req);
      int n;
      logic [CNT_W-1:0] hits;
      out_item_t want;
      if (req.opcode == OP_LOAD) begin
        ax[req.edge_index] = req.first_x;
        ay[req.edge_index] = req.first_y;
        bx[req.edge_index] = req.second_x;
        by[req.edge_index] = req.second_y;
        return;
      end
      n = (edge_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(edge_count);
      hits = '0;
      for (int j = 0; j < n; j++) hits += ray_crosses(req.point_x, req.point_y, j);
      want.crossings = hits;
      want.batch_end = req.last_point;
      crossings_q.push_back(want);
    endfunction

    task report(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(input out_item_t got);
      out_item_t want;
      if (crossings_q.size() == 0) begin
        report($sformatf("unexpected result crossings=%0d batch_end=%0b",
                         got.crossings, got.batch_end));
        return;
      end
      want = crossings_q.pop_front();
      if (got.crossings !== want.crossings)
        report($sformatf("crossings got %0d want %0d", got.crossings, want.crossings));
      if (got.batch_end !== want.batch_end)
        report($sformatf("batch_end got %0b want %0b", got.batch_end, want.batch_end));
    endtask

    task flag_leftovers();
      if (crossings_q.size() != 0)
        report($sformatf("%0d results never arrived", crossings_q.size()));
    endtask
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  in_item_t             in_i        = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  out_item_t            out_o;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [CNT_W-1:0]     cfg_data_i  = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;

  crossing_scoreboard sb = new();

  bit offering  = 1'b0;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;
  int idle_pct  = 15;
  int sent_items = 0;
  int unsigned cycles = 0;

  point_in_polygon_crossing_count_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_o       (out_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.set_edge_count(cfg_data_i);
      if (in_valid_i && !in_stall_o) sb.note_request(in_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_o);
    end
  end

  // result side: short random stalls, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic coord_t rand_coord(input span_e span);
    coord_t c;
    case (span)
      SPAN_TINY: c = int'($urandom_range(0, 16)) - 8;
      SPAN_MID:  c = int'($urandom_range(0, 2000)) - 1000;
      SPAN_FULL: c = $urandom;
      default: begin
        case ($urandom_range(0, 7))
          0: c = C_MIN;
          1: c = C_MAX;
          2: c = C_MIN + 1;
          3: c = C_MAX - 1;
          4: c = -1;
          5: c = 0;
          default: c = $urandom;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic in_item_t make_load(input logic [IDX_W-1:0] idx, input coord_t x1,
                                         input coord_t y1, input coord_t x2, input coord_t y2);
    in_item_t it;
    it.opcode     = OP_LOAD;
    it.edge_index = idx;
    it.first_x    = x1;
    it.first_y    = y1;
    it.second_x   = x2;
    it.second_y   = y2;
    it.point_x    = $urandom;
    it.point_y    = $urandom;
    it.last_point = $urandom_range(0, 1);
    return it;
  endfunction

  function automatic in_item_t make_query(input coord_t px, input coord_t py, input logic last);
    in_item_t it;
    it.opcode     = OP_QUERY;
    it.edge_index = $urandom_range(0, TABLE_DEPTH - 1);
    it.first_x    = $urandom;
    it.first_y    = $urandom;
    it.second_x   = $urandom;
    it.second_y   = $urandom;
    it.point_x    = px;
    it.point_y    = py;
    it.last_point = last;
    return it;
  endfunction

  task automatic send_request(input in_item_t it);
    if (offering && !calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_i       <= it;
    in_valid_i <= 1'b1;
    offering = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sent_items++;
    calm = (sent_items >= ITEM_GOAL - CALM_ITEMS);
  endtask

  task automatic lower_valid();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic wait_drained();
    lower_valid();
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_edge_count(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // load a mostly closed polygon in the used entries, then query points near it
  task automatic run_phase(input int n_cfg, input bit hold, input bit pause);
    coord_t vx [TABLE_DEPTH];
    coord_t vy [TABLE_DEPTH];
    coord_t x1, y1, x2, y2, px, py;
    span_e span;
    int k, q, a, b;
    logic last;
    write_edge_count(n_cfg);
    k = (n_cfg > TABLE_DEPTH) ? TABLE_DEPTH : n_cfg;
    span = span_e'($urandom_range(0, 3));
    if ($urandom_range(0, 1) == 0) span = SPAN_TINY;
    idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 15;
    for (int i = 0; i < k; i++) begin
      vx[i] = rand_coord(span);
      vy[i] = rand_coord(span);
    end
    for (int i = 0; i < k; i++) begin
      x1 = vx[i];
      y1 = vy[i];
      x2 = vx[(i + 1) % k];
      y2 = vy[(i + 1) % k];
      case ($urandom_range(0, 11))
        0: begin
          x1 = rand_coord(span);
          y1 = rand_coord(span);
          x2 = rand_coord(span);
          y2 = rand_coord(span);
        end
        1: y2 = y1;
        default: ;
      endcase
      send_request(make_load(i, x1, y1, x2, y2));
    end
    q = hold ? 16 : $urandom_range(3, 16);
    if (hold) hold_req = 1'b1;
    for (int i = 0; i < q; i++) begin
      if (pause && i == q / 2) wait_drained();
      if ($urandom_range(0, 9) == 0) begin
        send_request(make_load($urandom_range(0, TABLE_DEPTH - 1), rand_coord(span),
                               rand_coord(span), rand_coord(span), rand_coord(span)));
        continue;
      end
      px = rand_coord(span);
      py = rand_coord(span);
      if (k > 0) begin
        a = $urandom_range(0, k - 1);
        b = (a + 1) % k;
        case ($urandom_range(0, 4))
          1: py = vy[a];
          2: begin
            px = vx[a];
            py = vy[a];
          end
          3: begin
            px = (longint'(vx[a]) + longint'(vx[b])) / 2;
            py = (longint'(vy[a]) + longint'(vy[b])) / 2;
          end
          default: ;
        endcase
      end
      last = (i == q - 1) || ($urandom_range(0, 7) == 0);
      send_request(make_query(px, py, last));
    end
  endtask

  initial begin
    int n, r, phase_no;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // no edges in use: every count is zero
    write_edge_count(0);
    send_request(make_query(0, 0, 1'b1));
    send_request(make_query(C_MIN, C_MAX, 1'b0));

    // square at the coordinate extremes, two of its edges horizontal
    send_request(make_load(0, C_MIN, C_MIN, C_MAX, C_MIN));
    send_request(make_load(1, C_MAX, C_MIN, C_MAX, C_MAX));
    send_request(make_load(2, C_MAX, C_MAX, C_MIN, C_MAX));
    send_request(make_load(3, C_MIN, C_MAX, C_MIN, C_MIN));
    write_edge_count(4);
    send_request(make_query(0, 0, 1'b0));
    send_request(make_query(C_MIN, C_MIN, 1'b0));
    send_request(make_query(C_MAX, C_MAX, 1'b1));
    send_request(make_query(C_MAX, 0, 1'b0));
    send_request(make_query(C_MIN, 0, 1'b1));

    // small triangle: vertex, on-edge and half-open boundary points
    send_request(make_load(0, 0, 0, 10, 0));
    send_request(make_load(1, 10, 0, 0, 10));
    send_request(make_load(2, 0, 10, 0, 0));
    send_request(make_load(3, -5, -5, 5, 5));
    send_request(make_query(5, 5, 1'b0));
    send_request(make_query(4, 5, 1'b0));
    send_request(make_query(0, 0, 1'b0));
    send_request(make_query(0, 10, 1'b0));
    send_request(make_query(-1, 3, 1'b0));
    send_request(make_query(0, 5, 1'b0));
    send_request(make_query(2, 2, 1'b1));

    // full-span diagonal: products near the top of their range
    send_request(make_load(3, C_MIN, C_MIN, C_MAX, C_MAX));
    send_request(make_query(C_MIN, C_MAX - 1, 1'b0));
    send_request(make_query(C_MAX, C_MIN + 1, 1'b1));

    sent_items = 0;
    run_phase(0, 1'b0, 1'b0);
    run_phase(63, 1'b0, 1'b0);
    run_phase(32, 1'b0, 1'b0);
    phase_no = 0;
    while (sent_items < ITEM_GOAL) begin
      r = $urandom_range(0, 9);
      if (r == 0) n = 0;
      else if (r < 7) n = $urandom_range(1, 8);
      else if (r < 9) n = $urandom_range(9, 32);
      else n = $urandom_range(33, 63);
      if (phase_no == 3 && n == 0) n = 4;
      run_phase(n, phase_no == 3, phase_no == 6);
      phase_no++;
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
